@@ sv/wat_pkg.sv @@
// ----------------------------------------------------------------------------
// wat_pkg: shared types and constants of the average true range unit
// Holds the sequencer state type, the fixed field widths and the reset period.
// ----------------------------------------------------------------------------
package wat_pkg;

  // fixed field widths and the reset period
  localparam int OUT_W        = 48;
  localparam int PERIOD_W     = 8;
  localparam int COUNT_W      = 9;
  localparam int PERIOD_RESET = 14;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } wat_state_t;

endpackage

@@ sv/wilder_average_true_range_unit.sv @@
// ----------------------------------------------------------------------------
// wilder_average_true_range_unit: smoothed true range of a price bar stream
// One bar in, one average out; mean phase first, then the Wilder recursion.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | sink      | in_tvalid/in_tready  | bar_high, bar_low, bar_close
//  out_    | source    | out_tvalid/out_tready| atr_value
//  cfg_    | sink      | cfg_valid/cfg_ready  | atr_period
//
//  Divide: a restoring divider, one quotient bit per cycle through the shared
//  adder, produces DIV_W quotient bits for each bar in both phases.
//  The multiply by n-1 in the Wilder phase makes PERIOD_W passes through the
//  same adder, one per multiplier bit.
//  Reset: synchronous, active low; period returns to 14, all history clears.
//  Stalls: in_tready is low while a bar is worked on; a finished result
//  waits in the output register, and the next bar may enter meanwhile.
//
module wilder_average_true_range_unit
  import wat_pkg::*;
#(
  parameter int PRICE_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // bar_high, bar_low, bar_close (lowest bits first), zero padded to bytes
  input  logic [((3*PRICE_BITS+7)/8)*8-1:0]        in_tdata,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // atr_value
  output logic [OUT_W-1:0]                         out_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // atr_period
  input  logic [PERIOD_W-1:0]                      cfg_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready
);

  localparam int SUM_W  = PRICE_BITS + PERIOD_W;
  localparam int MEAN_W = SUM_W + FRACTION_BITS;
  localparam int WILD_W = OUT_W + PERIOD_W + 1;
  localparam int TRS_W  = PRICE_BITS + FRACTION_BITS + 1;
  localparam int DIV_A  = (MEAN_W > WILD_W) ? MEAN_W : WILD_W;
  localparam int DIV_W  = (DIV_A > TRS_W) ? DIV_A : TRS_W;
  localparam int ADD_W  = DIV_W + 1;
  localparam int CNT_W  = $clog2(DIV_W);

  // state and datapath registers
  wat_state_t             state_r, state_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic [COUNT_W-1:0]     bars_r, bars_nxt;
  logic [PRICE_BITS-1:0]  prev_close_r, prev_close_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [OUT_W-1:0]       avg_r, avg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic [PRICE_BITS-1:0]  hi_r, hi_nxt;
  logic [PRICE_BITS-1:0]  lo_r, lo_nxt;
  logic [PRICE_BITS-1:0]  cl_r, cl_nxt;
  logic [PRICE_BITS-1:0]  tr_r, tr_nxt;
  logic                   mean_r, mean_nxt;
  logic [DIV_W-1:0]       acc_r, acc_nxt;
  logic [DIV_W-1:0]       mcand_r, mcand_nxt;
  logic [PERIOD_W-1:0]    mplier_r, mplier_nxt;
  logic [COUNT_W-1:0]     rem_r, rem_nxt;
  logic [COUNT_W-1:0]     divisor_r, divisor_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  // shared adder / subtractor
  logic [ADD_W-1:0]       add_a, add_b, add_res;
  logic                   add_sub;

  // combinational helpers
  logic [PERIOD_W-1:0]    n_eff;
  logic [COUNT_W:0]       rem_sh;
  logic [PRICE_BITS-1:0]  hl_diff, dh_diff, dl_diff, tr_val;
  logic [OUT_W-1:0]       quot_sat;
  logic                   out_free;

  assign n_eff     = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign rem_sh    = {rem_r, acc_r[DIV_W-1]};
  assign quot_sat  = (|acc_r[DIV_W-1:OUT_W]) ? {OUT_W{1'b1}} : acc_r[OUT_W-1:0];
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // true range: saturating high-low, widened by the gaps to the last close after the first bar
  always_comb begin
    hl_diff = (hi_r > lo_r) ? (hi_r - lo_r) : '0;
    dh_diff = (hi_r >= prev_close_r) ? (hi_r - prev_close_r) : (prev_close_r - hi_r);
    dl_diff = (lo_r >= prev_close_r) ? (lo_r - prev_close_r) : (prev_close_r - lo_r);
    tr_val  = hl_diff;
    if (bars_r != '0) begin
      if (dh_diff > tr_val) tr_val = dh_diff;
      if (dl_diff > tr_val) tr_val = dl_diff;
    end
  end

  // select shared adder operands per step
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        add_a = ADD_W'(sum_r);
        add_b = ADD_W'(tr_r);
      end
      ST_MUL: begin
        add_a = ADD_W'(acc_r);
        add_b = ADD_W'(mcand_r);
      end
      ST_DIV: begin
        add_a   = ADD_W'(rem_sh);
        add_b   = ADD_W'(divisor_r);
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign add_res = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    period_nxt     = period_r;
    bars_nxt       = bars_r;
    prev_close_nxt = prev_close_r;
    sum_nxt        = sum_r;
    avg_nxt        = avg_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    cl_nxt         = cl_r;
    tr_nxt         = tr_r;
    mean_nxt       = mean_r;
    acc_nxt        = acc_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    rem_nxt        = rem_r;
    divisor_nxt    = divisor_r;
    cnt_nxt        = cnt_r;

    // drop the result once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    // take a period write
    if (cfg_valid && cfg_ready) period_nxt = cfg_data;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          hi_nxt    = in_tdata[PRICE_BITS-1:0];
          lo_nxt    = in_tdata[2*PRICE_BITS-1:PRICE_BITS];
          cl_nxt    = in_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
          state_nxt = ST_RANGE;
        end
      end
      ST_RANGE: begin
        tr_nxt    = tr_val;
        mean_nxt  = (bars_r <= {1'b0, n_eff});
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        if (mean_r) begin
          // accumulate and divide by the bar count
          sum_nxt     = add_res[SUM_W-1:0];
          acc_nxt     = DIV_W'(add_res[SUM_W-1:0]) << FRACTION_BITS;
          divisor_nxt = bars_r + COUNT_W'(1);
          state_nxt   = ST_DIV;
        end else begin
          // start avg * (n-1) on top of the scaled true range
          acc_nxt     = DIV_W'(tr_r) << FRACTION_BITS;
          mcand_nxt   = DIV_W'(avg_r);
          mplier_nxt  = n_eff - PERIOD_W'(1);
          divisor_nxt = COUNT_W'(n_eff);
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mplier_r[0]) acc_nxt = add_res[DIV_W-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PERIOD_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring step: quotient bit enters at the bottom
        if (!add_res[ADD_W-1]) begin
          rem_nxt = add_res[COUNT_W-1:0];
          acc_nxt = {acc_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[COUNT_W-1:0];
          acc_nxt = {acc_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = quot_sat;
          avg_nxt        = quot_sat;
          prev_close_nxt = cl_r;
          if (mean_r) bars_nxt = bars_r + COUNT_W'(1);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      period_r     <= PERIOD_W'(PERIOD_RESET);
      bars_r       <= '0;
      prev_close_r <= '0;
      sum_r        <= '0;
      avg_r        <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      period_r     <= period_nxt;
      bars_r       <= bars_nxt;
      prev_close_r <= prev_close_nxt;
      sum_r        <= sum_nxt;
      avg_r        <= avg_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    cl_r       <= cl_nxt;
    tr_r       <= tr_nxt;
    mean_r     <= mean_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    rem_r      <= rem_nxt;
    divisor_r  <= divisor_nxt;
  end

endmodule
